// ===== design/tkcs_pkg.sv =====
// tkcs_pkg: shared constants, config register indexes and the
// command/status structs that join the controller and the datapath
// no dependencies

package tkcs_pkg;

    // default depth of the sorted value store
    localparam int MAX_TOP_DEFAULT = 512;
    // thresholds honored at most, and threshold registers present
    localparam int MAX_THRESHOLDS  = 6;
    localparam int NUM_THR_REGS    = 6;

    // field widths
    localparam int VALUE_W    = 32;
    localparam int SUM_W      = 41;
    localparam int THR_W      = 10;
    localparam int TCNT_W     = 3;
    localparam int KIDX_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FIRST = 3'd1;

    // saturation limit of the running sum
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic item_load;   // latch the accepted input transaction
        logic ins_start;   // pick insertion slot, read its upper neighbor (the smallest value when full)
        logic chk_pass;    // full store: new value beats the smallest, read next
        logic cmp_move;    // shift the neighbor down one slot, read the next one
        logic cmp_place;   // write the new value into its slot
        logic drain_init;  // clear sum, position and threshold pointer
        logic sum_read;    // read the value at the summing position
        logic sum_acc;     // add the read value, advance the position
        logic emit;        // load the output register, advance threshold pointer
        logic col_clear;   // empty the store for the next column
    } tkcs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic has;       // latched transaction carries a value
        logic col_end;   // latched transaction ends the column
        logic full;      // store holds its maximum count
        logic drop;      // new value not above the smallest kept value
        logic move;      // neighbor above the slot is smaller than the new value
        logic n_zero;    // no thresholds in use
        logic sum_more;  // more values to add for the current threshold
        logic out_free;  // output register can take a result this cycle
        logic k_last;    // current threshold is the last one in use
    } tkcs_status_t;

endpackage

// ===== design/tkcs_ctrl.sv =====
// tkcs_ctrl: sequencer for insertion into the sorted store and the
// drain that produces the per-threshold sums
// depends on tkcs_pkg

module tkcs_ctrl
    import tkcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  tkcs_status_t status,
    output tkcs_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_CHK    = 3'd2;
    localparam logic [2:0] ST_CMP    = 3'd3;
    localparam logic [2:0] ST_SUMCHK = 3'd4;
    localparam logic [2:0] ST_ACC    = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        logic ins_done;
        ins_done   = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                if (status.has) begin
                    cmd.ins_start = 1'b1;
                    state_next    = status.full ? ST_CHK : ST_CMP;
                end else begin
                    ins_done = 1'b1;
                end
            end
            ST_CHK: begin
                if (status.drop) begin
                    ins_done = 1'b1;
                end else begin
                    cmd.chk_pass = 1'b1;
                    state_next   = ST_CMP;
                end
            end
            ST_CMP: begin
                if (status.move) begin
                    cmd.cmp_move = 1'b1;
                end else begin
                    cmd.cmp_place = 1'b1;
                    ins_done      = 1'b1;
                end
            end
            ST_SUMCHK: begin
                if (status.sum_more) begin
                    cmd.sum_read = 1'b1;
                    state_next   = ST_ACC;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_ACC: begin
                cmd.sum_acc = 1'b1;
                state_next  = ST_SUMCHK;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.k_last) begin
                        cmd.col_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_SUMCHK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // insertion finished: idle, or at column end start the drain (clear the store if no thresholds)
        if (ins_done) begin
            if (!status.col_end) begin
                state_next = ST_IDLE;
            end else if (status.n_zero) begin
                cmd.col_clear = 1'b1;
                state_next    = ST_IDLE;
            end else begin
                cmd.drain_init = 1'b1;
                state_next     = ST_SUMCHK;
            end
        end
    end

endmodule

// ===== design/tkcs_datapath.sv =====
// tkcs_datapath: sorted value store, insertion pointer, fill count,
// saturating accumulator, threshold registers and output register
// depends on tkcs_pkg

module tkcs_datapath
    import tkcs_pkg::*;
#(
    parameter int MAX_TOP = MAX_TOP_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input payload
    input  logic [VALUE_W-1:0]    s_sample_value,
    input  logic                  s_has_value,
    input  logic                  s_column_end,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SUM_W-1:0]      m_top_sum,
    output logic [KIDX_W-1:0]     m_threshold_index,
    output logic                  m_run_last,
    // controller link
    input  tkcs_cmd_t             cmd,
    output tkcs_status_t          status
);

    localparam int AW   = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
    localparam int CW   = $clog2(MAX_TOP + 1);
    localparam int CMPW = (CW > THR_W) ? CW : THR_W;

    // sorted store, descending
    logic [VALUE_W-1:0] mem [MAX_TOP];
    logic [VALUE_W-1:0] rdata_reg;

    logic [VALUE_W-1:0] v_reg;
    logic               has_reg;
    logic               end_reg;
    logic [AW-1:0]      p_reg;
    logic [CW-1:0]      filled_reg;
    logic [CW-1:0]      pos_reg;
    logic [SUM_W-1:0]   total_reg;
    logic [KIDX_W-1:0]  k_reg;

    logic [TCNT_W-1:0]  tcnt_reg;
    logic [THR_W-1:0]   thr_reg [NUM_THR_REGS];

    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic [KIDX_W-1:0]  out_idx_reg;
    logic               out_last_reg;

    logic               full;
    logic               rd_en;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      ins_slot;
    logic [TCNT_W-1:0]  n_eff;
    logic [THR_W-1:0]   thr_sel;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;

    assign full  = (filled_reg == CW'(MAX_TOP));
    assign n_eff = (tcnt_reg > TCNT_W'(MAX_THRESHOLDS)) ? TCNT_W'(MAX_THRESHOLDS) : tcnt_reg;
    assign thr_sel = thr_reg[k_reg];

    // slot for a new value: end of the store, or its last slot when full
    assign ins_slot = full ? AW'(MAX_TOP - 1) : filled_reg[AW-1:0];

    // read address select
    always_comb begin
        rd_en = cmd.ins_start | cmd.chk_pass | cmd.cmp_move | cmd.sum_read;
        raddr = pos_reg[AW-1:0];
        if (cmd.ins_start) begin
            raddr = full ? AW'(MAX_TOP - 1) : AW'(filled_reg - CW'(1));
        end else if (cmd.chk_pass) begin
            raddr = p_reg - AW'(1);
        end else if (cmd.cmp_move) begin
            raddr = p_reg - AW'(2);
        end
    end

    // store write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.cmp_move) begin
            mem[p_reg] <= rdata_reg;
        end else if (cmd.cmp_place) begin
            mem[p_reg] <= v_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    // saturating add of the read value
    assign sum_wide = {1'b0, total_reg} + (SUM_W + 1)'(rdata_reg);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    // item latch, insertion pointer, drain state
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            v_reg   <= s_sample_value;
            has_reg <= s_has_value;
            end_reg <= s_column_end;
        end
        if (cmd.ins_start) begin
            p_reg <= ins_slot;
        end else if (cmd.cmp_move) begin
            p_reg <= p_reg - AW'(1);
        end
        if (cmd.drain_init) begin
            total_reg <= '0;
            pos_reg   <= '0;
            k_reg     <= '0;
        end else begin
            if (cmd.sum_acc) begin
                total_reg <= sum_sat;
                pos_reg   <= pos_reg + CW'(1);
            end
            if (cmd.emit) begin
                k_reg <= k_reg + KIDX_W'(1);
            end
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
        end else if (cmd.col_clear) begin
            filled_reg <= '0;
        end else if (cmd.ins_start && !full) begin
            filled_reg <= filled_reg + CW'(1);
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcnt_reg <= '0;
            for (int i = 0; i < NUM_THR_REGS; i++) begin
                thr_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_THRESHOLD_COUNT) begin
                tcnt_reg <= cfg_data[TCNT_W-1:0];
            end
            for (int i = 0; i < NUM_THR_REGS; i++) begin
                if (cfg_index == CFG_THRESHOLD_FIRST + CFG_IDX_W'(i)) begin
                    thr_reg[i] <= cfg_data[THR_W-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_sum_reg  <= total_reg;
            out_idx_reg  <= k_reg;
            out_last_reg <= status.k_last;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_top_sum         = out_sum_reg;
    assign m_threshold_index = out_idx_reg;
    assign m_run_last        = out_last_reg;

    // status to the controller
    always_comb begin
        status.has      = has_reg;
        status.col_end  = end_reg;
        status.full     = full;
        status.drop     = !(rdata_reg < v_reg);
        status.move     = (p_reg != '0) && (rdata_reg < v_reg);
        status.n_zero   = (n_eff == '0);
        status.sum_more = (CMPW'(pos_reg) < CMPW'(thr_sel)) && (pos_reg < filled_reg);
        status.out_free = !out_valid_reg || m_ready;
        status.k_last   = (KIDX_W'(k_reg) == KIDX_W'(n_eff - TCNT_W'(1)));
    end

endmodule

// ===== design/top_k_cumulative_sum_core.sv =====
// top_k_cumulative_sum_core: top level, keeps the largest values of a column
// sorted and emits the sum of the largest N values for each threshold
// depends on tkcs_pkg, tkcs_ctrl, tkcs_datapath
//
//  channel  | ports                                           | direction
//  ---------+-------------------------------------------------+----------
//  input    | s_valid s_ready s_sample_value s_has_value      | in
//           | s_column_end                                    |
//  result   | m_valid m_ready m_top_sum m_threshold_index     | out
//           | m_run_last                                      |
//  config   | cfg_wr_en cfg_index cfg_data                    | in
//
// one transaction at a time: a latched value moves up the store slot by slot,
// after a check against the smallest when full; no value or a drop ends the insertion
// at column end each threshold adds its summed values, then emits its result
// synchronous active-low reset; the store needs no clearing pass
// a stalled result stalls the drain; the final one waits while the next input is taken

module top_k_cumulative_sum_core
    import tkcs_pkg::*;
#(
    parameter int MAX_TOP = MAX_TOP_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_W-1:0]    s_sample_value,
    input  logic                  s_has_value,
    input  logic                  s_column_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SUM_W-1:0]      m_top_sum,
    output logic [KIDX_W-1:0]     m_threshold_index,
    output logic                  m_run_last
);

    tkcs_cmd_t    cmd;
    tkcs_status_t status;

    // sequencer
    tkcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // store, accumulator and registers
    tkcs_datapath #(
        .MAX_TOP (MAX_TOP)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_sample_value    (s_sample_value),
        .s_has_value       (s_has_value),
        .s_column_end      (s_column_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_top_sum         (m_top_sum),
        .m_threshold_index (m_threshold_index),
        .m_run_last        (m_run_last),
        .cmd               (cmd),
        .status            (status)
    );

endmodule
